// ----- sv/pus_pkg.sv -----
// ----------------------------------------------------------------------------
// Particle update package
// Shared types, register codes, reset values and saturation helper for the
// particle update step core.
// ----------------------------------------------------------------------------
package pus_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [2:0] {
    REG_FRAME_DELTA = 3'd0,
    REG_CAMERA_X    = 3'd1,
    REG_CAMERA_Y    = 3'd2,
    REG_CAMERA_Z    = 3'd3,
    REG_DRAG_FACTOR = 3'd4,
    REG_RISE_RATE   = 3'd5,
    REG_GROWTH_RATE = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    COLOUR_HOT    = 2'd0,
    COLOUR_ORANGE = 2'd1,
    COLOUR_SMOKE  = 2'd2
  } colour_e;

  typedef struct packed {
    logic [31:0]      frame_delta;
    logic [2:0][31:0] camera;
    logic [31:0]      drag_factor;
    logic [31:0]      rise_rate;
    logic [31:0]      growth_rate;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    frame_delta: 32'd1092,
    camera:      '0,
    drag_factor: 32'd3951369912,
    rise_rate:   32'd128849,
    growth_rate: 32'd128849
  };

  typedef struct packed {
    logic             alive;
    logic [31:0]      life;
    colour_e          stage;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [31:0]      size;
  } queue_item_t;

  function automatic logic [31:0] sat_s34(logic [33:0] v);
    logic [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ----- sv/pus_front.sv -----
// ----------------------------------------------------------------------------
// Particle update front end
// Accepts particle records, decides liveness, takes the frame delta off the
// life and sorts the record into a colour stage before queueing it.
// ----------------------------------------------------------------------------
module pus_front import pus_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] in_life_i,
  input  logic [30:0]        in_max_life_i,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic signed [31:0] in_pos_z_i,
  input  logic signed [31:0] in_vel_x_i,
  input  logic signed [31:0] in_vel_y_i,
  input  logic signed [31:0] in_vel_z_i,
  input  logic [31:0]        in_size_i,
  input  logic [31:0]        frame_delta_i,
  input  logic               q_full_i,
  output logic               push_o,
  output queue_item_t        push_item_o
);

  typedef struct packed {
    logic             alive;
    logic [31:0]      life;
    logic [30:0]      max_life;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [31:0]      size;
  } front_item_t;

  front_item_t item_q, item_d;
  logic        valid_q;
  logic        accept;
  logic [33:0] life_diff;
  logic [36:0] life_ext, max_ext, life_x10, max_x7, max_x4;

  assign push_o     = valid_q && !q_full_i;
  assign in_ready_o = !valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign life_diff = {{2{in_life_i[31]}}, in_life_i} - {2'b00, frame_delta_i};

  always_comb begin
    item_d.alive    = !in_life_i[31] && (in_life_i != '0);
    item_d.life     = sat_s34(life_diff);
    item_d.max_life = in_max_life_i;
    item_d.pos      = {in_pos_z_i, in_pos_y_i, in_pos_x_i};
    item_d.vel      = {in_vel_z_i, in_vel_y_i, in_vel_x_i};
    item_d.size     = in_size_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  // Stage thresholds at seven and four tenths of the initial life, compared exactly.
  assign life_ext = {{5{item_q.life[31]}}, item_q.life};
  assign max_ext  = {6'd0, item_q.max_life};
  assign life_x10 = (life_ext << 3) + (life_ext << 1);
  assign max_x7   = (max_ext << 3) - max_ext;
  assign max_x4   = max_ext << 2;

  always_comb begin
    push_item_o.alive = item_q.alive;
    push_item_o.life  = item_q.life;
    push_item_o.pos   = item_q.pos;
    push_item_o.vel   = item_q.vel;
    push_item_o.size  = item_q.size;
    if ($signed(life_x10) > $signed(max_x7)) begin
      push_item_o.stage = COLOUR_HOT;
    end else if ($signed(life_x10) > $signed(max_x4)) begin
      push_item_o.stage = COLOUR_ORANGE;
    end else begin
      push_item_o.stage = COLOUR_SMOKE;
    end
  end

endmodule

// ----- sv/pus_queue.sv -----
// ----------------------------------------------------------------------------
// Particle update queue
// Short first-in first-out buffer that decouples the front end from the
// arithmetic back end.
// ----------------------------------------------------------------------------
module pus_queue import pus_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  queue_item_t push_item_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        head_valid_o,
  output queue_item_t head_item_o
);

  queue_item_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign full_o       = (count_q == (QPtrW + 1)'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Item pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("Item popped from an empty queue.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPtrW + 1)'(QDepth))
    else $error("Queue fill count exceeds its depth.");

endmodule

// ----- sv/pus_back.sv -----
// ----------------------------------------------------------------------------
// Particle update back end
// Five stage arithmetic pipeline: products, integration and saturation,
// camera offset, squares, then distance sum into the output register.
// ----------------------------------------------------------------------------
module pus_back import pus_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        head_valid_i,
  input  queue_item_t head_item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        alive_o,
  output logic signed [31:0] new_life_o,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic signed [31:0] new_pos_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic [31:0]        new_size_o,
  output logic [1:0]         colour_stage_o,
  output logic [31:0]        camera_dist_sq_o
);

  logic                adv;
  logic [4:0]          vld_q;
  logic signed [64:0]  prod_fd [3];
  logic signed [64:0]  prod_dg [3];
  logic [63:0]         rise_prod, grow_prod;
  queue_item_t         s1_item_q, s2_item_q, s3_item_q, s4_item_q, out_q, s2_d;
  logic [2:0][31:0]    s1_step_q, s1_nv_q;
  logic [31:0]         s1_rise_q, s1_grow_q;
  logic [32:0]         size_sum;
  logic [32:0]         cam_diff [3];
  logic [32:0]         cam_neg [3];
  logic [2:0][31:0]    s3_mag_q;
  logic [63:0]         sq [3];
  logic [2:0][47:0]    s4_sq_q;
  logic [49:0]         dist_sum;
  logic [31:0]         dist_sat, dist_q;

  assign adv         = !vld_q[4] || out_ready_i;
  assign pop_o       = adv && head_valid_i;
  assign out_valid_o = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], head_valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_fd[i] = $signed(head_item_i.vel[i]) * $signed({1'b0, cfg_i.frame_delta});
      prod_dg[i] = $signed(head_item_i.vel[i]) * $signed({1'b0, cfg_i.drag_factor});
    end
    rise_prod = cfg_i.rise_rate * cfg_i.frame_delta;
    grow_prod = cfg_i.growth_rate * cfg_i.frame_delta;
  end

  always_comb begin
    s2_d = s1_item_q;
    for (int i = 0; i < 3; i++) begin
      s2_d.pos[i] = s1_item_q.pos[i] + s1_step_q[i];
    end
    s2_d.vel[0] = s1_nv_q[0];
    s2_d.vel[1] = sat_s34({{2{s1_nv_q[1][31]}}, s1_nv_q[1]} + {2'b00, s1_rise_q});
    s2_d.vel[2] = s1_nv_q[2];
    size_sum    = {1'b0, s1_item_q.size} + {1'b0, s1_grow_q};
    s2_d.size   = size_sum[32] ? '1 : size_sum[31:0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam_diff[i] = {s2_item_q.pos[i][31], s2_item_q.pos[i]}
                  - {cfg_i.camera[i][31], cfg_i.camera[i]};
      cam_neg[i]  = '0 - cam_diff[i];
      sq[i]       = s3_mag_q[i] * s3_mag_q[i];
    end
    dist_sum = {2'b00, s4_sq_q[0]} + {2'b00, s4_sq_q[1]} + {2'b00, s4_sq_q[2]};
    dist_sat = (dist_sum[49:32] != '0) ? '1 : dist_sum[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q <= head_item_i;
      for (int i = 0; i < 3; i++) begin
        s1_step_q[i] <= prod_fd[i][47:16];
        s1_nv_q[i]   <= prod_dg[i][63:32];
        s3_mag_q[i]  <= cam_diff[i][32] ? cam_neg[i][31:0] : cam_diff[i][31:0];
        s4_sq_q[i]   <= sq[i][63:16];
      end
      s1_rise_q <= rise_prod[63:32];
      s1_grow_q <= grow_prod[63:32];
      s2_item_q <= s2_d;
      s3_item_q <= s2_item_q;
      s4_item_q <= s3_item_q;
      out_q     <= s4_item_q.alive ? s4_item_q : '0;
      dist_q    <= s4_item_q.alive ? dist_sat : '0;
    end
  end

  assign alive_o          = out_q.alive;
  assign new_life_o       = out_q.life;
  assign new_pos_x_o      = out_q.pos[0];
  assign new_pos_y_o      = out_q.pos[1];
  assign new_pos_z_o      = out_q.pos[2];
  assign new_vel_x_o      = out_q.vel[0];
  assign new_vel_y_o      = out_q.vel[1];
  assign new_vel_z_o      = out_q.vel[2];
  assign new_size_o       = out_q.size;
  assign colour_stage_o   = out_q.stage;
  assign camera_dist_sq_o = dist_q;

  a_dead_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !alive_o) |-> (new_life_o == '0 && new_size_o == '0 &&
      colour_stage_o == '0 && camera_dist_sq_o == '0 && new_pos_x_o == '0))
    else $error("Dead item carries nonzero result fields.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && !out_ready_i) |=> (vld_q == $past(vld_q)))
    else $error("Back-end pipeline moved while the output was stalled.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_q) && $stable(dist_q)))
    else $error("Output item changed while it was waiting.");

endmodule

// ----- sv/particle_update_step_core.sv -----
// ----------------------------------------------------------------------------
// Particle update step core
// Advances one particle record by one frame in Q16.16 fixed point.
//
//   Channel   Handshake                    Payload
//   input     in_valid_i / in_ready_o      in_life_i .. in_size_i
//   output    out_valid_o / out_ready_i    alive_o .. camera_dist_sq_o
//   config    cfg_wr_en_i (no wait)        cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while in_ready_o is high; out_valid_o rises
// after the front register, the queue and the five back-end stages.
// The back end is a five stage pipeline built around the 32 by 32 multipliers.
// Reset restores the configuration registers to their documented defaults and
// empties the pipeline. A stalled output freezes the back end while the front
// end keeps taking items until its four-entry queue is full.
// ----------------------------------------------------------------------------
module particle_update_step_core import pus_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] in_life_i,
  input  logic [30:0]        in_max_life_i,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic signed [31:0] in_pos_z_i,
  input  logic signed [31:0] in_vel_x_i,
  input  logic signed [31:0] in_vel_y_i,
  input  logic signed [31:0] in_vel_z_i,
  input  logic [31:0]        in_size_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               alive_o,
  output logic signed [31:0] new_life_o,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic signed [31:0] new_pos_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic [31:0]        new_size_o,
  output logic [1:0]         colour_stage_o,
  output logic [31:0]        camera_dist_sq_o
);

  cfg_t        cfg_q;
  logic        push, q_full, pop, head_valid;
  queue_item_t push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_wr_en_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_DELTA: cfg_q.frame_delta <= cfg_data_i;
        REG_CAMERA_X:    cfg_q.camera[0]   <= cfg_data_i;
        REG_CAMERA_Y:    cfg_q.camera[1]   <= cfg_data_i;
        REG_CAMERA_Z:    cfg_q.camera[2]   <= cfg_data_i;
        REG_DRAG_FACTOR: cfg_q.drag_factor <= cfg_data_i;
        REG_RISE_RATE:   cfg_q.rise_rate   <= cfg_data_i;
        REG_GROWTH_RATE: cfg_q.growth_rate <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pus_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_life_i     (in_life_i),
    .in_max_life_i (in_max_life_i),
    .in_pos_x_i    (in_pos_x_i),
    .in_pos_y_i    (in_pos_y_i),
    .in_pos_z_i    (in_pos_z_i),
    .in_vel_x_i    (in_vel_x_i),
    .in_vel_y_i    (in_vel_y_i),
    .in_vel_z_i    (in_vel_z_i),
    .in_size_i     (in_size_i),
    .frame_delta_i (cfg_q.frame_delta),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  pus_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  pus_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_valid_i     (head_valid),
    .head_item_i      (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .alive_o          (alive_o),
    .new_life_o       (new_life_o),
    .new_pos_x_o      (new_pos_x_o),
    .new_pos_y_o      (new_pos_y_o),
    .new_pos_z_o      (new_pos_z_o),
    .new_vel_x_o      (new_vel_x_o),
    .new_vel_y_o      (new_vel_y_o),
    .new_vel_z_o      (new_vel_z_o),
    .new_size_o       (new_size_o),
    .colour_stage_o   (colour_stage_o),
    .camera_dist_sq_o (camera_dist_sq_o)
  );

endmodule
